// ----- rtl/euler_to_quaternion_defines.svh -----
// Assertion helpers for the top-level RTL file.
`ifndef EULER_TO_QUATERNION_DEFINES_SVH
`define EULER_TO_QUATERNION_DEFINES_SVH
// Property that must hold on every clock edge outside reset.
`define E2Q_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Property with an implication, antecedent then consequent in the next cycle.
`define E2Q_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ----- rtl/e2q_pkg.sv -----
package e2q_pkg;

	localparam int ANGLE_WIDTH_DEF   = 16;
	localparam int QUAT_WIDTH_DEF    = 16;
	localparam int CORDIC_STAGES_DEF = 14;

	// Internal datapath: Q30 plus sign and fold headroom
	localparam int IW = 34;

	localparam logic signed [IW-1:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [IW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [IW-1:0] GAIN_Q30    = 34'sd652032874;
	localparam int ATAN_ENTRIES = 31;

	typedef logic signed [IW-1:0] word_t;

	// Arctangent table, atan(2^-i) scaled by 2^30
	function automatic word_t atan_q30(input logic [4:0] i);
		word_t r;
		begin
			case (i)
				5'd0: r = 34'sd843314856;
				5'd1: r = 34'sd497837829;
				5'd2: r = 34'sd263043836;
				5'd3: r = 34'sd133525158;
				5'd4: r = 34'sd67021686;
				5'd5: r = 34'sd33543515;
				5'd6: r = 34'sd16775850;
				5'd7: r = 34'sd8388437;
				5'd8: r = 34'sd4194282;
				5'd9: r = 34'sd2097149;
				5'd10: r = 34'sd1048575;
				5'd11: r = 34'sd524287;
				5'd12: r = 34'sd262143;
				5'd13: r = 34'sd131071;
				5'd14: r = 34'sd65535;
				5'd15: r = 34'sd32767;
				5'd16: r = 34'sd16383;
				5'd17: r = 34'sd8191;
				5'd18: r = 34'sd4095;
				5'd19: r = 34'sd2047;
				5'd20: r = 34'sd1023;
				5'd21: r = 34'sd511;
				5'd22: r = 34'sd255;
				5'd23: r = 34'sd127;
				5'd24: r = 34'sd63;
				5'd25: r = 34'sd31;
				5'd26: r = 34'sd15;
				5'd27: r = 34'sd7;
				5'd28: r = 34'sd3;
				5'd29: r = 34'sd1;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

	// Trig of the three half angles, travels between pipeline sections
	typedef struct packed {
		word_t cp;
		word_t sp;
		word_t cr;
		word_t sr;
		word_t cy;
		word_t sy;
	} trig_t;

endpackage

// ----- rtl/euler_to_quaternion.sv -----
// Euler angles to quaternion.
// Input channel s_axis: tdata carries pitch, roll and yaw as full angles
// in radians, signed Q3.(ANGLE_WIDTH-3). Output channel m_axis: tdata carries
// quaternion x, y, z, w, signed Q1.(QUAT_WIDTH-2), saturated to +/-1.0.
// Each result passes through the fold register, the CORDIC iteration stages,
// the unfold register, two multiply stages, sum and clamp; a valid shift
// register of matching length tracks which stages hold a transaction.
// Throughput is one transaction per cycle while the output is not stalled.
// The whole pipeline advances together as a single enable; when the receiver
// holds m_axis_tready low with a result waiting, the pipeline freezes and
// s_axis_tready drops. While the output slot is empty the pipeline keeps
// moving whatever m_axis_tready does, so nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
module euler_to_quaternion import e2q_pkg::*; #(
	parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
	parameter int QUAT_WIDTH    = QUAT_WIDTH_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// pitch_angle, roll_angle, yaw_angle from bit 0 up
	input  logic [3*ANGLE_WIDTH-1:0]  s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// quat_x, quat_y, quat_z, quat_w from bit 0 up
	output logic [4*QUAT_WIDTH-1:0]   m_axis_tdata
);

	`include "euler_to_quaternion_defines.svh"

	localparam int NST = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
	localparam int LAT = NST + 6;

	logic [LAT-1:0] vld_q;
	logic           adv;
	trig_t          trig;
	logic signed [QUAT_WIDTH-1:0] qx, qy, qz, qw;

	// Advance whenever the output slot is free or being taken
	assign adv = !vld_q[LAT-1] || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = vld_q[LAT-1];
	assign m_axis_tdata = {qw, qz, qy, qx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
		end
	end

	e2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
		.clk(clk), .adv(adv),
		.angle(s_axis_tdata[ANGLE_WIDTH-1:0]), .cos_o(trig.cp), .sin_o(trig.sp)
	);
	e2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_roll (
		.clk(clk), .adv(adv),
		.angle(s_axis_tdata[2*ANGLE_WIDTH-1:ANGLE_WIDTH]), .cos_o(trig.cr), .sin_o(trig.sr)
	);
	e2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
		.clk(clk), .adv(adv),
		.angle(s_axis_tdata[3*ANGLE_WIDTH-1:2*ANGLE_WIDTH]), .cos_o(trig.cy),
		.sin_o(trig.sy)
	);

	e2q_combine #(.QUAT_WIDTH(QUAT_WIDTH)) u_combine (
		.clk(clk), .adv(adv), .trig(trig),
		.qx(qx), .qy(qy), .qz(qz), .qw(qw)
	);

	`E2Q_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready,
		"input stalled with empty output")
	`E2Q_ASSERT_NEXT(a_hold_stall, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(vld_q), "pipeline moved during stall")
	`E2Q_ASSERT(a_clamp_w,
		m_axis_tvalid |-> ($signed(qw) <= $signed(QUAT_WIDTH'(1) <<< (QUAT_WIDTH-2))),
		"quat_w beyond one")

endmodule

// ----- rtl/e2q_cordic.sv -----
// Pipelined rotation-mode CORDIC: one stage per iteration, fold before the first.
module e2q_cordic import e2q_pkg::*; #(
	parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                          clk,
	input  logic                          adv,
	input  logic signed [ANGLE_WIDTH-1:0] angle,
	output word_t                         cos_o,
	output word_t                         sin_o
);

	localparam int NST = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

	word_t x_s [NST+1];
	word_t y_s [NST+1];
	word_t z_s [NST+1];
	logic  neg_s [NST+1];

	word_t h;
	word_t hf;
	logic  neg;

	// Scale to Q30 and fold into +/- pi/2
	always_comb begin
		h = word_t'(angle) <<< (32 - ANGLE_WIDTH);
		hf = h;
		neg = 1'b0;
		if (h > HALF_PI_Q30) begin
			hf = h - PI_Q30;
			neg = 1'b1;
		end else if (h < -HALF_PI_Q30) begin
			hf = h + PI_Q30;
			neg = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0] <= GAIN_Q30;
			y_s[0] <= '0;
			z_s[0] <= hf;
			neg_s[0] <= neg;
		end
	end

	// One micro-rotation per stage
	for (genvar i = 0; i < NST; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (adv) begin
				neg_s[i+1] <= neg_s[i];
				if (!z_s[i][IW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_q30(5'(i));
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_q30(5'(i));
				end
			end
		end
	end

	// Undo the fold
	always_ff @(posedge clk) begin
		if (adv) begin
			cos_o <= neg_s[NST] ? -x_s[NST] : x_s[NST];
			sin_o <= neg_s[NST] ? -y_s[NST] : y_s[NST];
		end
	end

endmodule

// ----- rtl/e2q_combine.sv -----
// Triple products, sums and output rounding, four register stages.
module e2q_combine import e2q_pkg::*; #(
	parameter int QUAT_WIDTH = QUAT_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         adv,
	input  trig_t                        trig,
	output logic signed [QUAT_WIDTH-1:0] qx,
	output logic signed [QUAT_WIDTH-1:0] qy,
	output logic signed [QUAT_WIDTH-1:0] qz,
	output logic signed [QUAT_WIDTH-1:0] qw
);

	localparam int SH = 32 - QUAT_WIDTH;
	localparam int PW = 2 * IW;

	// Pair products: cy*sr, sy*cr, cy*cr, sy*sr, plus third factors
	word_t p_s1 [4];
	word_t c_s1 [8];
	word_t t_s2 [8];
	logic signed [IW+1:0] v_s3 [4];

	logic signed [PW-1:0] m1 [4];
	logic signed [PW-1:0] m2 [8];

	always_comb begin
		m1[0] = PW'(trig.cy) * PW'(trig.sr);
		m1[1] = PW'(trig.sy) * PW'(trig.cr);
		m1[2] = PW'(trig.cy) * PW'(trig.cr);
		m1[3] = PW'(trig.sy) * PW'(trig.sr);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) p_s1[k] <= word_t'(m1[k] >>> 30);
			c_s1[0] <= trig.cp; c_s1[1] <= trig.sp;
			c_s1[2] <= trig.sp; c_s1[3] <= trig.cp;
			c_s1[4] <= trig.cp; c_s1[5] <= trig.sp;
			c_s1[6] <= trig.cp; c_s1[7] <= trig.sp;
		end
	end

	// Terms: x = a0 - a1, y = a2 + a3, z = a4 - a5, w = a6 + a7
	always_comb begin
		m2[0] = PW'(p_s1[0]) * PW'(c_s1[0]);
		m2[1] = PW'(p_s1[1]) * PW'(c_s1[1]);
		m2[2] = PW'(p_s1[2]) * PW'(c_s1[2]);
		m2[3] = PW'(p_s1[3]) * PW'(c_s1[3]);
		m2[4] = PW'(p_s1[1]) * PW'(c_s1[4]);
		m2[5] = PW'(p_s1[0]) * PW'(c_s1[5]);
		m2[6] = PW'(p_s1[2]) * PW'(c_s1[6]);
		m2[7] = PW'(p_s1[3]) * PW'(c_s1[7]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 8; k++) t_s2[k] <= word_t'(m2[k] >>> 30);
		end
	end

	function automatic logic signed [IW+1:0] rnd(input logic signed [IW+1:0] v);
		logic signed [IW+1:0] r;
		begin
			if (SH > 0) r = (v + ((IW+2)'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
			else r = v;
			return r;
		end
	endfunction

	// Combine and round half up
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				if (k == 0 || k == 2)
					v_s3[k] <= rnd((IW+2)'(t_s2[2*k]) - (IW+2)'(t_s2[2*k+1]));
				else
					v_s3[k] <= rnd((IW+2)'(t_s2[2*k]) + (IW+2)'(t_s2[2*k+1]));
			end
		end
	end

	// Clamp to +/- 1.0
	function automatic logic signed [QUAT_WIDTH-1:0] sat(input logic signed [IW+1:0] v);
		logic signed [IW+1:0] lim;
		logic signed [IW+1:0] r;
		begin
			lim = (IW+2)'(1) <<< (QUAT_WIDTH - 2);
			r = v;
			if (v > lim) r = lim;
			if (v < -lim) r = -lim;
			return r[QUAT_WIDTH-1:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			qx <= sat(v_s3[0]);
			qy <= sat(v_s3[1]);
			qz <= sat(v_s3[2]);
			qw <= sat(v_s3[3]);
		end
	end

endmodule

// ----- test/euler_to_quaternion_test.sv -----
`timescale 1ns / 100ps

module euler_to_quaternion_test;
	import e2q_pkg::*;

	localparam int AW = 16;
	localparam int QW = 16;
	localparam int STAGES = 14;
	localparam int LATENCY = STAGES + 6;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int N_RANDOM = 2000;

	typedef logic signed [AW-1:0] angle_t;
	typedef logic signed [QW-1:0] comp_t;

	typedef struct packed {
		comp_t w;
		comp_t z;
		comp_t y;
		comp_t x;
	} quat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [3*AW-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [4*QW-1:0] m_axis_tdata;

	// pending angle triples, pitch in the lowest bits
	logic [3*AW-1:0] angle_queue[$];
	quat_t quat_expected[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit stimulus_done = 0;
	bit hold_off = 0;
	int tx_gap = 0;
	int rx_gap = 0;

	euler_to_quaternion u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	// cosine and sine of half the angle, Q30
	function automatic void half_angle_trig(input angle_t a, output longint c,
			output longint s);
		longint h;
		longint cx;
		longint cy;
		longint dx;
		longint dy;
		bit flip;
		h = longint'(a) * (longint'(1) << (32 - AW));
		flip = 0;
		cx = longint'(GAIN_Q30);
		cy = 0;
		if (h > longint'(HALF_PI_Q30)) begin
			h -= longint'(PI_Q30);
			flip = 1;
		end else if (h < -longint'(HALF_PI_Q30)) begin
			h += longint'(PI_Q30);
			flip = 1;
		end
		for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
			dx = floor_shift(cy, i);
			dy = floor_shift(cx, i);
			if (h >= 0) begin
				cx -= dx;
				cy += dy;
				h -= longint'(atan_q30(i[4:0]));
			end else begin
				cx += dx;
				cy -= dy;
				h += longint'(atan_q30(i[4:0]));
			end
		end
		c = flip ? -cx : cx;
		s = flip ? -cy : cy;
	endfunction

	function automatic longint prod3(longint a, longint b, longint c);
		return floor_shift(floor_shift(a * b, 30) * c, 30);
	endfunction

	function automatic comp_t round_clamp(longint v);
		longint lim;
		lim = longint'(1) << (QW - 2);
		if (32 - QW > 0)
			v = floor_shift(v + (longint'(1) << (31 - QW)), 32 - QW);
		if (v > lim)
			v = lim;
		if (v < -lim)
			v = -lim;
		return comp_t'(v);
	endfunction

	function automatic quat_t euler_quat(logic [3*AW-1:0] d);
		longint cp, sp, cr, sr, cy, sy;
		quat_t q;
		half_angle_trig(d[AW-1:0], cp, sp);
		half_angle_trig(d[2*AW-1:AW], cr, sr);
		half_angle_trig(d[3*AW-1:2*AW], cy, sy);
		q.x = round_clamp(prod3(cy, sr, cp) - prod3(sy, cr, sp));
		q.y = round_clamp(prod3(cy, cr, sp) + prod3(sy, sr, cp));
		q.z = round_clamp(prod3(sy, cr, cp) - prod3(cy, sr, sp));
		q.w = round_clamp(prod3(cy, cr, cp) + prod3(sy, sr, sp));
		return q;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 60)
			return 0;
		if ($urandom_range(0, 99) < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic angle_t rand_angle();
		case ($urandom_range(0, 9))
			0: return angle_t'($urandom);
			1: return angle_t'($urandom_range(0, 8)) - 4 + angle_t'(12868);
			2: return angle_t'(25736) - angle_t'($urandom_range(0, 4));
			default: return angle_t'(int'($urandom_range(0, 51472)) - 25736);
		endcase
	endfunction

	// fill the stimulus queue, then release reset
	initial begin
		angle_t corner[10];
		corner = '{16'sh0000, 16'sh7fff, -16'sh8000, 16'sd25736, -16'sd25736,
			16'sd12868, -16'sd12868, 16'sd1, -16'sd1, 16'sd6434};
		foreach (corner[i])
			angle_queue.push_back({corner[(i+2)%10], corner[(i+1)%10], corner[i]});
		angle_queue.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff});
		angle_queue.push_back({-16'sh8000, -16'sh8000, -16'sh8000});
		angle_queue.push_back({16'sd12868, 16'sd25736, 16'sd0});
		angle_queue.push_back({16'hffff, 16'hffff, 16'hffff});
		angle_queue.push_back({16'h5555, 16'haaaa, 16'h5555});
		for (int n = 0; n < N_RANDOM; n++)
			angle_queue.push_back({rand_angle(), rand_angle(), rand_angle()});
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// drive the slave side
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				quat_expected.push_back(euler_quat(s_axis_tdata));
				tx_gap = pick_gap();
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (angle_queue.size() > 0) begin
					s_axis_tdata <= angle_queue.pop_front();
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
					stimulus_done = 1;
				end
			end
		end
	end

	// long receiver hold-off so the pipeline fills and back-pressures
	initial begin
		@(posedge arst_n);
		repeat (300) @(posedge clk);
		hold_off = 1;
		repeat (200) @(posedge clk);
		hold_off = 0;
	end

	// check results on the master side
	always @(posedge clk) begin
		quat_t got;
		quat_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (quat_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transaction %h", got);
				end else begin
					want = quat_expected.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch x %0d/%0d y %0d/%0d z %0d/%0d w %0d/%0d (exp/act)",
								want.x, got.x, want.y, got.y, want.z, got.z,
								want.w, got.w);
					end
				end
			end
			if (hold_off) begin
				m_axis_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				rx_gap = pick_gap();
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("euler_to_quaternion_test: FAIL");
			$finish;
		end
	end

	// finish once everything has drained
	initial begin
		wait (stimulus_done && quat_expected.size() == 0);
		repeat (LATENCY * 4) @(posedge clk);
		if (mismatches == 0 && quat_expected.size() == 0) begin
			$display("euler_to_quaternion_test: PASS");
		end else begin
			$display("euler_to_quaternion_test: FAIL");
		end
		$finish;
	end

endmodule
